[rtl/ddld_pkg.sv]
// ---------------------------------------------------------------------------
// ddld_pkg
// Types and constants shared by the dual-device layer dispatch block.
// ---------------------------------------------------------------------------
package ddld_pkg;

   // transaction opcodes
   localparam logic [1:0] OpLayer    = 2'd0;
   localparam logic [1:0] OpSub      = 2'd1;
   localparam logic [1:0] OpMetrics  = 2'd2;
   localparam logic [1:0] OpFailover = 2'd3;

   // configuration register indexes
   localparam logic [2:0] RegSplitEnable = 3'd0;
   localparam logic [2:0] RegSubsPerLayer = 3'd1;
   localparam logic [2:0] RegStripeWidth = 3'd2;
   localparam logic [2:0] RegPrimaryWeight = 3'd3;
   localparam logic [2:0] RegHotLimit = 3'd4;
   localparam logic [2:0] RegReserveMib = 3'd5;
   localparam logic [2:0] RegTotalMemPrimary = 3'd6;
   localparam logic [2:0] RegTotalMemSecondary = 3'd7;

   // availability hysteresis, tenths of a degree
   localparam logic signed [11:0] TempOffLimit = 12'sd950;
   localparam logic signed [11:0] TempOnLimit  = 12'sd850;

   // clamps on the register values
   localparam logic [6:0] SubsMax   = 7'd64;
   localparam logic [7:0] WeightMin = 8'd26;
   localparam logic [7:0] WeightMax = 8'd230;

   // striping divider: 19-bit dividend, one quotient bit per cycle
   localparam int DivSteps = 19;
   localparam int DivCntW  = $clog2(DivSteps);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_DECIDE,
      ST_DIV,
      ST_RESP
   } state_type;

   // effective configuration, clamps already applied
   typedef struct packed {
      logic        split_enable;
      logic [6:0]  subs;
      logic [7:0]  stripe;
      logic [7:0]  weight;
      logic [11:0] hot_limit;
      logic [19:0] reserve;
      logic [19:0] total0;
      logic [19:0] total1;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic decide;
      logic div_step;
   } cmd_type;

   typedef struct packed {
      logic div_needed;
      logic div_last;
   } status_type;

endpackage

[rtl/ddld_csr.sv]
// ---------------------------------------------------------------------------
// ddld_csr
// Configuration registers with the clamps applied on the read side.
// ---------------------------------------------------------------------------
module ddld_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [19:0]      csr_wdata,
   output ddld_pkg::cfg_type cfg
);

   logic        split_ff,  split_in;
   logic [6:0]  subs_ff,   subs_in;
   logic [7:0]  stripe_ff, stripe_in;
   logic [7:0]  weight_ff, weight_in;
   logic [11:0] hot_ff,    hot_in;
   logic [19:0] resv_ff,   resv_in;
   logic [19:0] tot0_ff,   tot0_in;
   logic [19:0] tot1_ff,   tot1_in;
   logic        wr;

   assign csr_ready = 1'b1;
   assign wr = csr_valid & csr_ready;

   always_comb begin
      split_in  = split_ff;
      subs_in   = subs_ff;
      stripe_in = stripe_ff;
      weight_in = weight_ff;
      hot_in    = hot_ff;
      resv_in   = resv_ff;
      tot0_in   = tot0_ff;
      tot1_in   = tot1_ff;
      if (wr) begin
         unique case (csr_index)
            ddld_pkg::RegSplitEnable:       split_in  = csr_wdata[0];
            ddld_pkg::RegSubsPerLayer:      subs_in   = csr_wdata[6:0];
            ddld_pkg::RegStripeWidth:       stripe_in = csr_wdata[7:0];
            ddld_pkg::RegPrimaryWeight:     weight_in = csr_wdata[7:0];
            ddld_pkg::RegHotLimit:          hot_in    = csr_wdata[11:0];
            ddld_pkg::RegReserveMib:        resv_in   = csr_wdata;
            ddld_pkg::RegTotalMemPrimary:   tot0_in   = csr_wdata;
            ddld_pkg::RegTotalMemSecondary: tot1_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         split_ff  <= 1'b0;
         subs_ff   <= 7'd4;
         stripe_ff <= 8'd1;
         weight_ff <= 8'd179;
         hot_ff    <= 12'd850;
         resv_ff   <= 20'd2048;
         tot0_ff   <= 20'd0;
         tot1_ff   <= 20'd0;
      end else begin
         split_ff  <= split_in;
         subs_ff   <= subs_in;
         stripe_ff <= stripe_in;
         weight_ff <= weight_in;
         hot_ff    <= hot_in;
         resv_ff   <= resv_in;
         tot0_ff   <= tot0_in;
         tot1_ff   <= tot1_in;
      end
   end

   always_comb begin
      cfg.split_enable = split_ff;
      if (subs_ff == 7'd0)                  cfg.subs = 7'd1;
      else if (subs_ff > ddld_pkg::SubsMax) cfg.subs = ddld_pkg::SubsMax;
      else                                  cfg.subs = subs_ff;
      cfg.stripe = stripe_ff;
      if (weight_ff < ddld_pkg::WeightMin)      cfg.weight = ddld_pkg::WeightMin;
      else if (weight_ff > ddld_pkg::WeightMax) cfg.weight = ddld_pkg::WeightMax;
      else                                      cfg.weight = weight_ff;
      cfg.hot_limit = hot_ff;
      cfg.reserve   = resv_ff;
      cfg.total0    = tot0_ff;
      cfg.total1    = tot1_ff;
   end

endmodule

[rtl/ddld_ctrl.sv]
// ---------------------------------------------------------------------------
// ddld_ctrl
// Sequencer: capture, two multiply steps, decision, optional divide, response.
// ---------------------------------------------------------------------------
module ddld_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_strobe,
   output ddld_pkg::cmd_type    cmd,
   input  ddld_pkg::status_type status
);

   ddld_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ddld_pkg::ST_IDLE:   if (start) state_in = ddld_pkg::ST_MUL1;
         ddld_pkg::ST_MUL1:   state_in = ddld_pkg::ST_MUL2;
         ddld_pkg::ST_MUL2:   state_in = ddld_pkg::ST_DECIDE;
         ddld_pkg::ST_DECIDE: begin
            state_in = status.div_needed ? ddld_pkg::ST_DIV : ddld_pkg::ST_RESP;
         end
         ddld_pkg::ST_DIV:    if (status.div_last) state_in = ddld_pkg::ST_RESP;
         ddld_pkg::ST_RESP:   state_in = ddld_pkg::ST_IDLE;
         default:             state_in = ddld_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ddld_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ddld_pkg::ST_MUL1:   cmd.mul1 = 1'b1;
         ddld_pkg::ST_MUL2:   cmd.mul2 = 1'b1;
         ddld_pkg::ST_DECIDE: cmd.decide = 1'b1;
         ddld_pkg::ST_DIV:    cmd.div_step = 1'b1;
         ddld_pkg::ST_RESP:   rsp_strobe = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ddld_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not make the block busy");
   a_strobe_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("response strobe outside a transaction");
   a_div_after_decide: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && !$past(cmd.div_step)) |-> $past(cmd.decide))
      else $error("divider started without a decision step");
`endif

endmodule

[rtl/ddld_dp.sv]
// ---------------------------------------------------------------------------
// ddld_dp
// Datapath: operand capture, share multiplies, device state, decision logic
// and a radix-2 restoring divider for the stripe parity.
// ---------------------------------------------------------------------------
module ddld_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  ddld_pkg::cfg_type     cfg,
   input  ddld_pkg::cmd_type     cmd,
   output ddld_pkg::status_type  status,
   input  logic [1:0]            req_opcode,
   input  logic [11:0]           req_layer_index,
   input  logic [5:0]            req_sub_index,
   input  logic [12:0]           req_layer_total,
   input  logic [19:0]           req_need_mib,
   input  logic                  req_device_select,
   input  logic signed [11:0]    req_temp_tenths,
   input  logic [19:0]           req_used_mib,
   output logic                  rsp_chosen_device,
   output logic                  rsp_found,
   output logic                  rsp_avail_primary,
   output logic                  rsp_avail_secondary
);

   // captured transaction
   logic [1:0]         op_ff,    op_in;
   logic [11:0]        layer_ff, layer_in;
   logic [5:0]         sub_ff,   sub_in;
   logic [12:0]        total_ff, total_in;
   logic [19:0]        need_ff,  need_in;
   logic               dsel_ff,  dsel_in;
   logic signed [11:0] temp_ff,  temp_in;
   logic [19:0]        used_ff,  used_in;

   // intermediate values
   logic [18:0] n_ff,     n_in;
   logic [26:0] needx_ff, needx_in;
   logic [17:0] base_ff,  base_in;
   logic [18:0] p_ff,     p_in;
   logic [18:0] g_ff,     g_in;
   logic [19:0] free0_ff, free0_in;
   logic [19:0] free1_ff, free1_in;
   logic        hot0_ff,  hot0_in;
   logic        hot1_ff,  hot1_in;

   // device state
   logic signed [11:0] dtemp_ff [2];
   logic signed [11:0] dtemp_in [2];
   logic [19:0]        dused_ff [2];
   logic [19:0]        dused_in [2];
   logic [1:0]         avail_ff, avail_in;

   // result and divider
   logic                       chosen_ff, chosen_in;
   logic                       found_ff,  found_in;
   logic [18:0]                dvd_ff,    dvd_in;
   logic [7:0]                 rem_ff,    rem_in;
   logic [ddld_pkg::DivCntW-1:0] cnt_ff,  cnt_in;

   // decision terms
   logic        is_sub;
   logic [18:0] base_x, base_end, layer_x, tgt, diff, cnt_sat;
   logic [26:0] p27;
   logic        dec_chosen, dec_div;
   logic [20:0] taken0, taken1;
   logic [8:0]  shifted;
   logic        q_bit;

   always_comb begin
      is_sub   = (op_ff == ddld_pkg::OpSub);
      base_x   = 19'(base_ff);
      base_end = base_x + 19'(cfg.subs);
      layer_x  = 19'(layer_ff);
      tgt      = is_sub ? g_ff : base_x;
      diff     = p_ff - base_x;
      cnt_sat  = (diff > 19'(cfg.subs)) ? 19'(cfg.subs) : diff;
      if (p_ff <= base_x) cnt_sat = '0;
      taken0   = 21'(dused_ff[0]) + 21'(cfg.reserve);
      taken1   = 21'(dused_ff[1]) + 21'(cfg.reserve);
      p27      = 27'(n_ff) * 27'(cfg.weight);

      dec_chosen = 1'b0;
      dec_div    = 1'b0;
      if (cfg.split_enable) begin
         if (hot0_ff && tgt < p_ff) begin
            dec_chosen = 1'b1;
         end else if (hot1_ff && (is_sub ? (g_ff >= p_ff) : (base_end > p_ff))) begin
            dec_chosen = 1'b0;
         end else if (cfg.stripe > 8'd1) begin
            dec_div = 1'b1;
         end else if (is_sub) begin
            dec_chosen = !(g_ff < p_ff);
         end else begin
            dec_chosen = !(cnt_sat >= 19'(cfg.subs >> 1));
         end
      end else begin
         if (hot0_ff && layer_x < p_ff) begin
            dec_chosen = 1'b1;
         end else if (hot1_ff && layer_x >= p_ff) begin
            dec_chosen = 1'b0;
         end else if (27'(free0_ff) < needx_ff && 27'(free1_ff) >= needx_ff) begin
            dec_chosen = 1'b1;
         end else if (27'(free1_ff) < needx_ff && 27'(free0_ff) >= needx_ff) begin
            dec_chosen = 1'b0;
         end else begin
            dec_chosen = !(layer_x < p_ff);
         end
      end

      shifted = {rem_ff, dvd_ff[18]};
      q_bit   = (shifted >= 9'(cfg.stripe));
   end

   // only assignment transactions use the divider
   assign status.div_needed = dec_div &&
                              (op_ff == ddld_pkg::OpLayer || op_ff == ddld_pkg::OpSub);
   assign status.div_last   = (cnt_ff == ddld_pkg::DivCntW'(ddld_pkg::DivSteps - 1));

   always_comb begin
      op_in = op_ff;  layer_in = layer_ff;  sub_in = sub_ff;  total_in = total_ff;
      need_in = need_ff;  dsel_in = dsel_ff;  temp_in = temp_ff;  used_in = used_ff;
      n_in = n_ff;  needx_in = needx_ff;  base_in = base_ff;  p_in = p_ff;  g_in = g_ff;
      free0_in = free0_ff;  free1_in = free1_ff;  hot0_in = hot0_ff;  hot1_in = hot1_ff;
      dtemp_in = dtemp_ff;  dused_in = dused_ff;  avail_in = avail_ff;
      chosen_in = chosen_ff;  found_in = found_ff;
      dvd_in = dvd_ff;  rem_in = rem_ff;  cnt_in = cnt_ff;

      if (cmd.load) begin
         op_in    = req_opcode;
         layer_in = req_layer_index;
         sub_in   = req_sub_index;
         total_in = req_layer_total;
         need_in  = req_need_mib;
         dsel_in  = req_device_select;
         temp_in  = req_temp_tenths;
         used_in  = req_used_mib;
      end

      if (cmd.mul1) begin
         n_in     = cfg.split_enable ? 19'(total_ff) * 19'(cfg.subs) : 19'(total_ff);
         needx_in = (op_ff == ddld_pkg::OpSub) ? 27'(need_ff) * 27'(cfg.subs)
                                               : 27'(need_ff);
         base_in  = 18'(layer_ff) * 18'(cfg.subs);
      end

      if (cmd.mul2) begin
         p_in     = p27[26:8];
         g_in     = base_x + 19'(sub_ff);
         free0_in = (21'(cfg.total0) > taken0) ? 20'(21'(cfg.total0) - taken0) : 20'd0;
         free1_in = (21'(cfg.total1) > taken1) ? 20'(21'(cfg.total1) - taken1) : 20'd0;
         hot0_in  = dtemp_ff[0] > $signed(cfg.hot_limit);
         hot1_in  = dtemp_ff[1] > $signed(cfg.hot_limit);
      end

      if (cmd.decide) begin
         dvd_in = tgt;
         rem_in = '0;
         cnt_in = '0;
         case (op_ff) inside
            ddld_pkg::OpLayer, ddld_pkg::OpSub: begin
               chosen_in = dec_chosen;
               found_in  = 1'b0;
            end
            ddld_pkg::OpMetrics: begin
               chosen_in = 1'b0;
               found_in  = 1'b0;
               dtemp_in[dsel_ff] = temp_ff;
               dused_in[dsel_ff] = used_ff;
               if (temp_ff > ddld_pkg::TempOffLimit)     avail_in[dsel_ff] = 1'b0;
               else if (temp_ff < ddld_pkg::TempOnLimit) avail_in[dsel_ff] = 1'b1;
            end
            default: begin
               found_in  = avail_ff[!dsel_ff];
               chosen_in = avail_ff[!dsel_ff] ? !dsel_ff : 1'b0;
            end
         endcase
      end

      if (cmd.div_step) begin
         dvd_in = {dvd_ff[17:0], 1'b0};
         rem_in = q_bit ? 8'(shifted - 9'(cfg.stripe)) : shifted[7:0];
         cnt_in = cnt_ff + 1'b1;
         // parity of the quotient is the last bit produced
         if (status.div_last) chosen_in = q_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dtemp_ff <= '{default: '0};
         dused_ff <= '{default: '0};
         avail_ff <= 2'b11;
         chosen_ff <= 1'b0;
         found_ff  <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         dtemp_ff  <= dtemp_in;
         dused_ff  <= dused_in;
         avail_ff  <= avail_in;
         chosen_ff <= chosen_in;
         found_ff  <= found_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;  layer_ff <= layer_in;  sub_ff <= sub_in;  total_ff <= total_in;
      need_ff <= need_in;  dsel_ff <= dsel_in;  temp_ff <= temp_in;  used_ff <= used_in;
      n_ff <= n_in;  needx_ff <= needx_in;  base_ff <= base_in;  p_ff <= p_in;
      g_ff <= g_in;  free0_ff <= free0_in;  free1_ff <= free1_in;
      hot0_ff <= hot0_in;  hot1_ff <= hot1_in;
      dvd_ff <= dvd_in;  rem_ff <= rem_in;
   end

   assign rsp_chosen_device   = chosen_ff;
   assign rsp_found           = found_ff;
   assign rsp_avail_primary   = avail_ff[0];
   assign rsp_avail_secondary = avail_ff[1];

`ifndef SYNTH
   a_found_only_failover: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.decide) && $past(op_ff) != ddld_pkg::OpFailover |-> !found_ff)
      else $error("found set on a non-failover transaction");
   a_avail_only_metrics: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.decide) |-> $stable(avail_ff))
      else $error("availability changed outside a metrics update");
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_step) |-> rem_ff < cfg.stripe)
      else $error("divider remainder not below the stripe width");
`endif

endmodule

[rtl/dual_device_layer_dispatch.sv]
// ---------------------------------------------------------------------------
// dual_device_layer_dispatch
// Chooses the primary or secondary device for a layer or sub-layer, tracks
// per-device temperature, memory use and availability, answers failover.
// ---------------------------------------------------------------------------
//  channel   handshake                    payload
//  request   start / busy                 req_opcode .. req_used_mib
//  response  rsp_strobe (one cycle)       rsp_chosen_device .. rsp_avail_secondary
//  config    csr_valid / csr_ready        csr_index, csr_wdata
//
//  A transaction is taken when start is high and busy is low; the response
//  strobe follows the capture, the two multiply steps and the decision step,
//  and when striping is in effect also the 19-step serial divider for the stripe parity.
//  The next transaction is taken the cycle after the strobe.
//  Synchronous active-high reset restores register defaults and device state.
//  The response cannot be stalled; csr_ready is always high.
// ---------------------------------------------------------------------------
module dual_device_layer_dispatch (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_opcode,
   input  logic [11:0]       req_layer_index,
   input  logic [5:0]        req_sub_index,
   input  logic [12:0]       req_layer_total,
   input  logic [19:0]       req_need_mib,
   input  logic              req_device_select,
   input  logic signed [11:0] req_temp_tenths,
   input  logic [19:0]       req_used_mib,
   output logic              rsp_strobe,
   output logic              rsp_chosen_device,
   output logic              rsp_found,
   output logic              rsp_avail_primary,
   output logic              rsp_avail_secondary,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [19:0]       csr_wdata
);

   ddld_pkg::cfg_type    cfg;
   ddld_pkg::cmd_type    cmd;
   ddld_pkg::status_type status;

   ddld_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ddld_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   ddld_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .cmd                 (cmd),
      .status              (status),
      .req_opcode          (req_opcode),
      .req_layer_index     (req_layer_index),
      .req_sub_index       (req_sub_index),
      .req_layer_total     (req_layer_total),
      .req_need_mib        (req_need_mib),
      .req_device_select   (req_device_select),
      .req_temp_tenths     (req_temp_tenths),
      .req_used_mib        (req_used_mib),
      .rsp_chosen_device   (rsp_chosen_device),
      .rsp_found           (rsp_found),
      .rsp_avail_primary   (rsp_avail_primary),
      .rsp_avail_secondary (rsp_avail_secondary)
   );

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for dual_device_layer_dispatch. A queue of requests
// feeds a clocked driver on the start/busy port. On every taken request a
// behavioral copy of the dispatcher works out the expected response. A
// monitor compares each response strobe with the oldest expected one. Phases
// of directed and random requests run under several register settings,
// extremes and out-of-range values among them.
// ---------------------------------------------------------------------------
module tb;

   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 30;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [11:0] layer_index;
      logic [5:0]  sub_index;
      logic [12:0] layer_total;
      logic [19:0] need_mib;
      logic        device_select;
      logic [11:0] temp_tenths;
      logic [19:0] used_mib;
   } dispatch_req_type;

   typedef struct packed {
      logic chosen_device;
      logic found;
      logic avail_primary;
      logic avail_secondary;
   } dispatch_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]        req_opcode = '0;
   logic [11:0]       req_layer_index = '0;
   logic [5:0]        req_sub_index = '0;
   logic [12:0]       req_layer_total = '0;
   logic [19:0]       req_need_mib = '0;
   logic              req_device_select = 1'b0;
   logic signed [11:0] req_temp_tenths = '0;
   logic [19:0]       req_used_mib = '0;
   logic              rsp_strobe;
   logic              rsp_chosen_device;
   logic              rsp_found;
   logic              rsp_avail_primary;
   logic              rsp_avail_secondary;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = '0;
   logic [19:0]       csr_wdata = '0;

   // register mirror
   logic              cfg_split = 1'b0;
   logic [6:0]        cfg_subs = 7'd4;
   logic [7:0]        cfg_stripe = 8'd1;
   logic [7:0]        cfg_weight = 8'd179;
   logic signed [11:0] cfg_hot = 12'sd850;
   logic [19:0]       cfg_reserve = 20'd2048;
   logic [19:0]       cfg_total0 = '0;
   logic [19:0]       cfg_total1 = '0;

   // per-device state as the dispatcher should hold it
   logic signed [11:0] dev_temp [2];
   logic [19:0]       dev_used [2];
   logic              dev_avail [2];

   dispatch_req_type pending_req [$];
   dispatch_rsp_type expected_rsp [$];
   dispatch_req_type cur;
   dispatch_rsp_type want;
   int gap_left = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int mismatch_count = 0;
   int mem_hi = 65535;

   dual_device_layer_dispatch dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_layer_index    (req_layer_index),
      .req_sub_index      (req_sub_index),
      .req_layer_total    (req_layer_total),
      .req_need_mib       (req_need_mib),
      .req_device_select  (req_device_select),
      .req_temp_tenths    (req_temp_tenths),
      .req_used_mib       (req_used_mib),
      .rsp_strobe         (rsp_strobe),
      .rsp_chosen_device  (rsp_chosen_device),
      .rsp_found          (rsp_found),
      .rsp_avail_primary  (rsp_avail_primary),
      .rsp_avail_secondary(rsp_avail_secondary),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic add_req(input dispatch_req_type r);
      pending_req.insert(pending_req.size(), r);
   endtask

   function automatic longint unsigned primary_share(input longint unsigned n);
      longint unsigned w;
      w = 64'(cfg_weight);
      if (w < 64'(ddld_pkg::WeightMin)) w = 64'(ddld_pkg::WeightMin);
      if (w > 64'(ddld_pkg::WeightMax)) w = 64'(ddld_pkg::WeightMax);
      return (n * w) >> 8;
   endfunction

   function automatic bit dev_hot(input logic d);
      return dev_temp[d] > cfg_hot;
   endfunction

   // free memory saturates at zero
   function automatic longint unsigned free_mib(input logic d);
      longint unsigned tot, taken;
      tot = d ? 64'(cfg_total1) : 64'(cfg_total0);
      taken = 64'(dev_used[d]);
      taken += 64'(cfg_reserve);
      return (tot > taken) ? tot - taken : 64'd0;
   endfunction

   function automatic bit legacy_pick(input longint unsigned layer, input longint unsigned total,
                                      input longint unsigned need);
      longint unsigned p, f0, f1;
      p = primary_share(total);
      if (dev_hot(1'b0) && layer < p) return 1'b1;
      if (dev_hot(1'b1) && layer >= p) return 1'b0;
      f0 = free_mib(1'b0);
      f1 = free_mib(1'b1);
      if (f0 < need && f1 >= need) return 1'b1;
      if (f1 < need && f0 >= need) return 1'b0;
      return (layer < p) ? 1'b0 : 1'b1;
   endfunction

   function automatic dispatch_rsp_type predict_dispatch(input dispatch_req_type r);
      dispatch_rsp_type o;
      longint unsigned subs, total, p, base, g, cnt, q;
      logic other;
      o = '0;
      subs = 64'(cfg_subs);
      if (subs < 64'd1) subs = 64'd1;
      if (subs > 64'(ddld_pkg::SubsMax)) subs = 64'(ddld_pkg::SubsMax);
      total = 64'(r.layer_total);
      p = primary_share(total * subs);
      base = 64'(r.layer_index);
      base = base * subs;
      g = base + 64'(r.sub_index);
      other = ~r.device_select;
      case (r.opcode)
         ddld_pkg::OpLayer: begin
            if (!cfg_split) begin
               o.chosen_device = legacy_pick(64'(r.layer_index), total, 64'(r.need_mib));
            end else if (dev_hot(1'b0) && base < p) begin
               o.chosen_device = 1'b1;
            end else if (dev_hot(1'b1) && base + subs > p) begin
               o.chosen_device = 1'b0;
            end else if (cfg_stripe > 8'd1) begin
               q = base / 64'(cfg_stripe);
               o.chosen_device = q[0];
            end else begin
               // majority of the layer's sub-layers inside the primary share
               cnt = (p > base) ? p - base : 64'd0;
               if (cnt > subs) cnt = subs;
               o.chosen_device = (cnt >= subs / 64'd2) ? 1'b0 : 1'b1;
            end
         end
         ddld_pkg::OpSub: begin
            if (!cfg_split) begin
               q = 64'(r.need_mib);
               o.chosen_device = legacy_pick(64'(r.layer_index), total, q * subs);
            end else if (dev_hot(1'b0) && g < p) begin
               o.chosen_device = 1'b1;
            end else if (dev_hot(1'b1) && g >= p) begin
               o.chosen_device = 1'b0;
            end else if (cfg_stripe > 8'd1) begin
               q = g / 64'(cfg_stripe);
               o.chosen_device = q[0];
            end else begin
               o.chosen_device = (g < p) ? 1'b0 : 1'b1;
            end
         end
         ddld_pkg::OpMetrics: begin
            dev_temp[r.device_select] = r.temp_tenths;
            dev_used[r.device_select] = r.used_mib;
            // hysteresis: flag kept between the two limits
            if ($signed(r.temp_tenths) > ddld_pkg::TempOffLimit)
               dev_avail[r.device_select] = 1'b0;
            else if ($signed(r.temp_tenths) < ddld_pkg::TempOnLimit)
               dev_avail[r.device_select] = 1'b1;
         end
         default: begin
            if (dev_avail[other]) begin
               o.chosen_device = other;
               o.found = 1'b1;
            end
         end
      endcase
      o.avail_primary = dev_avail[0];
      o.avail_secondary = dev_avail[1];
      return o;
   endfunction

   function automatic int idle_gap();
      int roll;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 3) begin
         burst_left = $urandom_range(60, 20);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 80) return $urandom_range(8, 1);
      if (roll < 95) return $urandom_range(30, 9);
      return $urandom_range(80, 31);
   endfunction

   function automatic dispatch_req_type mk_req(input int op, input int layer, input int sub,
                                               input int total, input int need, input int dsel,
                                               input int temp, input int used);
      dispatch_req_type r;
      r.opcode = op[1:0];
      r.layer_index = layer[11:0];
      r.sub_index = sub[5:0];
      r.layer_total = total[12:0];
      r.need_mib = need[19:0];
      r.device_select = dsel[0];
      r.temp_tenths = temp[11:0];
      r.used_mib = used[19:0];
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy)
            expected_rsp.insert(expected_rsp.size(), predict_dispatch(cur));
         if (!(start && busy)) begin
            if (gap_left > 0 || pending_req.size() == 0) begin
               if (gap_left > 0) gap_left--;
               start <= 1'b0;
            end else begin
               cur = pending_req.pop_front();
               req_opcode <= cur.opcode;
               req_layer_index <= cur.layer_index;
               req_sub_index <= cur.sub_index;
               req_layer_total <= cur.layer_total;
               req_need_mib <= cur.need_mib;
               req_device_select <= cur.device_select;
               req_temp_tenths <= cur.temp_tenths;
               req_used_mib <= cur.used_mib;
               start <= 1'b1;
               gap_left = idle_gap();
            end
         end
      end
   end

   task automatic check_field(input string what, input logic exp_bit, input logic act_bit);
      if (exp_bit !== act_bit) begin
         $display("%0t: %s mismatch, expected %0b actual %0b", $time, what, exp_bit, act_bit);
         mismatch_count++;
      end
   endtask

   // response monitor and watchdog
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: response with no transaction outstanding, expected none actual %b",
                     $time, {rsp_chosen_device, rsp_found, rsp_avail_primary,
                             rsp_avail_secondary});
            mismatch_count++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("chosen_device", want.chosen_device, rsp_chosen_device);
            check_field("found", want.found, rsp_found);
            check_field("avail_primary", want.avail_primary, rsp_avail_primary);
            check_field("avail_secondary", want.avail_secondary, rsp_avail_secondary);
         end
      end
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   // called right after a rising edge; valid stays up for back-to-back writes
   task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ddld_pkg::RegSplitEnable:     cfg_split = val[0];
         ddld_pkg::RegSubsPerLayer:    cfg_subs = val[6:0];
         ddld_pkg::RegStripeWidth:     cfg_stripe = val[7:0];
         ddld_pkg::RegPrimaryWeight:   cfg_weight = val[7:0];
         ddld_pkg::RegHotLimit:        cfg_hot = val[11:0];
         ddld_pkg::RegReserveMib:      cfg_reserve = val;
         ddld_pkg::RegTotalMemPrimary: cfg_total0 = val;
         default:                      cfg_total1 = val;
      endcase
   endtask

   task automatic program_settings(input int split_en, input int subs, input int stripe,
                                   input int weight, input int hot, input int reserve,
                                   input int tot0, input int tot1);
      write_reg(ddld_pkg::RegSplitEnable, split_en[19:0]);
      write_reg(ddld_pkg::RegSubsPerLayer, subs[19:0]);
      write_reg(ddld_pkg::RegStripeWidth, stripe[19:0]);
      write_reg(ddld_pkg::RegPrimaryWeight, weight[19:0]);
      write_reg(ddld_pkg::RegHotLimit, {8'd0, hot[11:0]});
      write_reg(ddld_pkg::RegReserveMib, reserve[19:0]);
      write_reg(ddld_pkg::RegTotalMemPrimary, tot0[19:0]);
      write_reg(ddld_pkg::RegTotalMemSecondary, tot1[19:0]);
      csr_valid <= 1'b0;
   endtask

   // returns on a rising edge once nothing is queued or outstanding
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_req.size() != 0 || start || expected_rsp.size() != 0);
      @(posedge clock);
   endtask

   task automatic run_random(input int count);
      dispatch_req_type r;
      int pick, total, t, subs_now;
      subs_now = int'(cfg_subs);
      if (subs_now < 1) subs_now = 1;
      if (subs_now > int'(ddld_pkg::SubsMax)) subs_now = int'(ddld_pkg::SubsMax);
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 30) r.opcode = ddld_pkg::OpLayer;
         else if (pick < 60) r.opcode = ddld_pkg::OpSub;
         else if (pick < 85) r.opcode = ddld_pkg::OpMetrics;
         else r.opcode = ddld_pkg::OpFailover;
         pick = $urandom_range(9);
         if (pick < 4) total = $urandom_range(64, 1);
         else if (pick < 8) total = $urandom_range(4096, 1);
         else if (pick == 8) total = 4096;
         else total = 0;
         r.layer_total = total[12:0];
         // mostly layers that belong to the model
         if (total > 0 && $urandom_range(99) < 85) t = $urandom_range(total - 1);
         else t = $urandom_range(4095);
         r.layer_index = t[11:0];
         if ($urandom_range(99) < 80) t = $urandom_range(subs_now - 1);
         else t = $urandom_range(63);
         r.sub_index = t[5:0];
         pick = $urandom_range(9);
         if (pick == 0) t = 0;
         else if (pick == 1) t = mem_hi;
         else if (pick < 5) t = $urandom_range(mem_hi / subs_now);
         else t = $urandom_range(mem_hi);
         r.need_mib = t[19:0];
         t = $urandom_range(1);
         r.device_select = t[0];
         // temperatures crowd the hysteresis limits and the hot limit
         pick = $urandom_range(9);
         if (pick < 3) t = int'($urandom_range(1900)) - 400;
         else if (pick < 5) t = 850 + int'($urandom_range(8)) - 4;
         else if (pick < 7) t = 950 + int'($urandom_range(8)) - 4;
         else begin
            t = int'(cfg_hot);
            t = t + int'($urandom_range(6)) - 3;
         end
         if (t < -400) t = -400;
         if (t > 1500) t = 1500;
         r.temp_tenths = t[11:0];
         t = $urandom_range(mem_hi);
         r.used_mib = t[19:0];
         add_req(r);
      end
      wait_drained();
   endtask

   initial begin
      int pick, split_en, subs, stripe, weight, hot;
      dev_temp[0] = '0;
      dev_temp[1] = '0;
      dev_used[0] = '0;
      dev_used[1] = '0;
      dev_avail[0] = 1'b1;
      dev_avail[1] = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // legacy mode: hysteresis, failover, memory check, thermal shift
      program_settings(0, 4, 1, 179, 850, 2048, 16384, 8192);
      add_req(mk_req(ddld_pkg::OpMetrics, 0, 0, 0, 0, 0, 960, 0));
      add_req(mk_req(ddld_pkg::OpFailover, 0, 0, 0, 0, 1, 0, 0));
      add_req(mk_req(ddld_pkg::OpFailover, 0, 0, 0, 0, 0, 0, 0));
      add_req(mk_req(ddld_pkg::OpMetrics, 0, 0, 0, 0, 0, 950, 0));
      add_req(mk_req(ddld_pkg::OpMetrics, 0, 0, 0, 0, 0, 849, 0));
      add_req(mk_req(ddld_pkg::OpMetrics, 0, 0, 0, 0, 0, 850, 0));
      add_req(mk_req(ddld_pkg::OpMetrics, 1, 0, 0, 0, 1, 1500, 1048575));
      add_req(mk_req(ddld_pkg::OpMetrics, 0, 0, 0, 0, 0, -400, 0));
      add_req(mk_req(ddld_pkg::OpLayer, 0, 0, 4096, 0, 0, 0, 0));
      add_req(mk_req(ddld_pkg::OpLayer, 4095, 63, 4096, 1048575, 0, 0, 0));
      add_req(mk_req(ddld_pkg::OpLayer, 10, 0, 100, 12000, 0, 0, 0));
      add_req(mk_req(ddld_pkg::OpMetrics, 0, 0, 0, 0, 1, 0, 100));
      add_req(mk_req(ddld_pkg::OpLayer, 90, 0, 100, 7000, 0, 0, 0));
      add_req(mk_req(ddld_pkg::OpLayer, 5, 0, 100, 15000, 0, 0, 0));
      add_req(mk_req(ddld_pkg::OpSub, 80, 2, 100, 1600, 0, 0, 0));
      add_req(mk_req(ddld_pkg::OpMetrics, 0, 0, 0, 0, 0, 851, 0));
      add_req(mk_req(ddld_pkg::OpLayer, 5, 0, 100, 0, 0, 0, 0));
      add_req(mk_req(ddld_pkg::OpMetrics, 0, 0, 0, 0, 1, 1000, 0));
      add_req(mk_req(ddld_pkg::OpLayer, 90, 0, 100, 0, 0, 0, 0));
      add_req(mk_req(ddld_pkg::OpMetrics, 0, 0, 0, 0, 0, 0, 0));
      wait_drained();

      // split mode, widest layers, sub-layer index past subs_per_layer
      program_settings(1, 64, 1, 26, 850, 0, 0, 0);
      add_req(mk_req(ddld_pkg::OpLayer, 0, 0, 4096, 0, 0, 0, 0));
      add_req(mk_req(ddld_pkg::OpLayer, 4095, 0, 4096, 0, 0, 0, 0));
      add_req(mk_req(ddld_pkg::OpSub, 4095, 63, 4096, 0, 0, 0, 0));
      wait_drained();
      program_settings(1, 3, 255, 230, 1500, 0, 0, 0);
      add_req(mk_req(ddld_pkg::OpSub, 10, 63, 20, 0, 0, 0, 0));
      add_req(mk_req(ddld_pkg::OpLayer, 7, 0, 0, 0, 0, 0, 0));
      wait_drained();

      // register extremes, then out-of-range register values
      mem_hi = 1048575;
      program_settings(1, 64, 255, 230, 1500, 1048575, 1048575, 1048575);
      run_random(100);
      mem_hi = 4095;
      program_settings(1, 1, 1, 26, -400, 0, 0, 0);
      run_random(100);
      mem_hi = 1048575;
      program_settings(0, 0, 0, 0, 1500, 0, 1048575, 0);
      run_random(60);
      program_settings(1, 127, 0, 255, -400, 1048575, 0, 1048575);
      run_random(60);

      for (int ph = 0; ph < 11; ph++) begin
         pick = $urandom_range(2);
         mem_hi = (pick == 0) ? 4095 : (pick == 1) ? 65535 : 1048575;
         split_en = $urandom_range(1);
         pick = $urandom_range(9);
         if (pick == 0) subs = 1;
         else if (pick == 1) subs = 64;
         else if (pick < 6) subs = $urandom_range(8, 1);
         else subs = $urandom_range(64, 1);
         pick = $urandom_range(9);
         if (pick < 4) stripe = 1;
         else if (pick < 8) stripe = $urandom_range(8, 2);
         else stripe = $urandom_range(255, 9);
         weight = $urandom_range(230, 26);
         hot = int'($urandom_range(1900)) - 400;
         program_settings(split_en, subs, stripe, weight, hot, $urandom_range(mem_hi / 4),
                          $urandom_range(mem_hi), $urandom_range(mem_hi));
         run_random(100);
      end

      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
